/* design/e2q_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and the arctangent table of the Euler-angle to
// quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int FracBitsDefault    = 16;
  localparam int CordicStepsDefault = 18;
  localparam int MaxSteps           = 32;
  localparam int AngleW             = 20;
  localparam int QuatW              = 18;
  localparam int OpW                = 2;

  // Q.32 working word of the CORDIC, and Q.30 sine/cosine word
  typedef logic signed [35:0] q32_t;
  typedef logic signed [33:0] q30_t;

  localparam q32_t Q32Pi     = 36'sd13493037705;
  localparam q32_t Q32HalfPi = 36'sd6746518852;
  localparam q32_t Q32Gain   = 36'sd2608131496;

  typedef enum logic [OpW-1:0] {
    OP_RPY = 2'd0,
    OP_XYZ = 2'd1,
    OP_ZXZ = 2'd2,
    OP_ZYX = 2'd3
  } op_e;

  function automatic q32_t atan_q32(input int idx);
    q32_t v;
    case (idx)
      0:  v = 36'sd3373259426;
      1:  v = 36'sd1991351318;
      2:  v = 36'sd1052175346;
      3:  v = 36'sd534100635;
      4:  v = 36'sd268086748;
      5:  v = 36'sd134174063;
      6:  v = 36'sd67103403;
      7:  v = 36'sd33553749;
      8:  v = 36'sd16777131;
      9:  v = 36'sd8388597;
      10: v = 36'sd4194303;
      default: v = q32_t'(36'sd1) <<< (32 - idx);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/e2q_cordic_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_cordic_lane
// Pipelined rotation CORDIC: sine and cosine of half of one angle, in Q.30.
// ----------------------------------------------------------------------------
module e2q_cordic_lane #(
  parameter int FRAC_BITS    = e2q_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = e2q_pkg::CordicStepsDefault
) (
  input  wire                               clk_i,
  input  wire                               en_i,
  input  wire logic signed [e2q_pkg::AngleW-1:0] angle_i,
  output e2q_pkg::q30_t                     sin_o,
  output e2q_pkg::q30_t                     cos_o
);
  import e2q_pkg::*;

  localparam int N = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

  q32_t x_q [0:N];
  q32_t y_q [0:N];
  q32_t z_q [0:N];
  logic flip_q [0:N];
  q32_t z_half;
  q32_t xf, yf;
  q30_t sin_q, cos_q;

  // half angle in Q.32
  assign z_half = q32_t'(angle_i) <<< (31 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= Q32Gain;
      y_q[0] <= '0;
      if (z_half > Q32HalfPi) begin
        z_q[0]    <= z_half - Q32Pi;
        flip_q[0] <= 1'b1;
      end else if (z_half < -Q32HalfPi) begin
        z_q[0]    <= z_half + Q32Pi;
        flip_q[0] <= 1'b1;
      end else begin
        z_q[0]    <= z_half;
        flip_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    q32_t dx, dy;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - atan_q32(i);
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + atan_q32(i);
        end
      end
    end
  end

  assign xf = flip_q[N] ? -x_q[N] : x_q[N];
  assign yf = flip_q[N] ? -y_q[N] : y_q[N];

  // round to Q.30
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= q30_t'((xf + 36'sd2) >>> 2);
      sin_q <= q30_t'((yf + 36'sd2) >>> 2);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

  // z residual of the last stage is not needed
  logic unused_z;
  assign unused_z = ^z_q[N];

endmodule
`default_nettype wire

/* design/e2q_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_merge
// Combines the three lanes' sines and cosines into the four components:
// pair products, triple products, then sum, round and saturate.
// ----------------------------------------------------------------------------
module e2q_merge #(
  parameter int FRAC_BITS = e2q_pkg::FracBitsDefault
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  e2q_pkg::op_e                 op_i,
  input  e2q_pkg::q30_t                sa_i,
  input  e2q_pkg::q30_t                ca_i,
  input  e2q_pkg::q30_t                sb_i,
  input  e2q_pkg::q30_t                cb_i,
  input  e2q_pkg::q30_t                sc_i,
  input  e2q_pkg::q30_t                cc_i,
  output logic signed [e2q_pkg::QuatW-1:0] quat_w_o,
  output logic signed [e2q_pkg::QuatW-1:0] quat_x_o,
  output logic signed [e2q_pkg::QuatW-1:0] quat_y_o,
  output logic signed [e2q_pkg::QuatW-1:0] quat_z_o
);
  import e2q_pkg::*;

  typedef logic signed [67:0] pq_t;
  typedef logic signed [37:0] t_t;
  typedef logic signed [71:0] tr_t;
  typedef logic signed [72:0] sum_t;

  q30_t p [8];
  q30_t q [8];
  q30_t r [8];
  logic [3:0] sub;

  q30_t r_q [8];
  t_t   t_q [8];
  tr_t  tr_q [8];
  logic [3:0] sub_a_q, sub_b_q;
  logic signed [QuatW-1:0] quat_q [4];

  // Operand order per angle order; entries 2k and 2k+1 form component k.
  always_comb begin
    case (op_i)
      OP_RPY: begin
        p = '{ca_i, sa_i, cb_i, ca_i, ca_i, cb_i, ca_i, cc_i};
        q = '{cb_i, sb_i, cc_i, sb_i, cc_i, sa_i, cb_i, sa_i};
        r = '{cc_i, sc_i, sa_i, sc_i, sb_i, sc_i, sc_i, sb_i};
        sub = 4'b1010;
      end
      OP_XYZ: begin
        p = '{ca_i, sa_i, cb_i, ca_i, ca_i, cb_i, ca_i, cc_i};
        q = '{cb_i, sb_i, cc_i, sb_i, cc_i, sa_i, cb_i, sa_i};
        r = '{cc_i, sc_i, sa_i, sc_i, sb_i, sc_i, sc_i, sb_i};
        sub = 4'b0101;
      end
      OP_ZXZ: begin
        p = '{ca_i, cb_i, ca_i, sa_i, cc_i, ca_i, ca_i, cb_i};
        q = '{cb_i, sa_i, cc_i, sb_i, sa_i, sb_i, cb_i, cc_i};
        r = '{cc_i, sc_i, sb_i, sc_i, sb_i, sc_i, sc_i, sa_i};
        sub = 4'b0101;
      end
      default: begin
        p = '{ca_i, sa_i, ca_i, cc_i, ca_i, cb_i, cb_i, ca_i};
        q = '{cb_i, sb_i, cb_i, sa_i, cc_i, sa_i, cc_i, sb_i};
        r = '{cc_i, sc_i, sc_i, sb_i, sb_i, sc_i, sa_i, sc_i};
        sub = 4'b1010;
      end
    endcase
  end

  for (genvar k = 0; k < 8; k++) begin : g_prod
    pq_t pq;
    assign pq = pq_t'(p[k]) * pq_t'(q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[k]  <= t_t'((pq + (pq_t'(1) <<< 29)) >>> 30);
        r_q[k]  <= r[k];
        tr_q[k] <= tr_t'(t_q[k]) * tr_t'(r_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sub_a_q <= sub;
      sub_b_q <= sub_a_q;
    end
  end

  // bit c of the sign pattern selects subtraction for component c
  for (genvar c = 0; c < 4; c++) begin : g_comp
    sum_t s, v;
    assign s = sub_b_q[c] ? sum_t'(tr_q[2*c]) - sum_t'(tr_q[2*c+1])
                          : sum_t'(tr_q[2*c]) + sum_t'(tr_q[2*c+1]);
    assign v = (s + (sum_t'(1) <<< (59 - FRAC_BITS))) >>> (60 - FRAC_BITS);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v > (sum_t'(1) <<< FRAC_BITS)) begin
          quat_q[c] <= QuatW'(sum_t'(1) <<< FRAC_BITS);
        end else if (v < -(sum_t'(1) <<< FRAC_BITS)) begin
          quat_q[c] <= QuatW'(-(sum_t'(1) <<< FRAC_BITS));
        end else begin
          quat_q[c] <= v[QuatW-1:0];
        end
      end
    end
  end

  assign quat_w_o = quat_q[0];
  assign quat_x_o = quat_q[1];
  assign quat_y_o = quat_q[2];
  assign quat_z_o = quat_q[3];

endmodule
`default_nettype wire

/* design/euler_to_quaternion_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Euler angles (Q3.16 radians) to unit quaternion (Q1.16), four angle orders.
// ----------------------------------------------------------------------------
// Fully pipelined: three CORDIC lanes, one per angle, each one stage per
// iteration, feed a three-stage product merge. An item is accepted every
// cycle unless the pipeline holds, which it does while a finished result
// waits on out_ready_i.
module euler_to_quaternion_unit #(
  parameter int FRAC_BITS    = e2q_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = e2q_pkg::CordicStepsDefault
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [e2q_pkg::OpW-1:0]          op_i,
  input  wire logic signed [e2q_pkg::AngleW-1:0] angle_a_i,
  input  wire logic signed [e2q_pkg::AngleW-1:0] angle_b_i,
  input  wire logic signed [e2q_pkg::AngleW-1:0] angle_c_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [e2q_pkg::QuatW-1:0]      quat_w_o,
  output logic signed [e2q_pkg::QuatW-1:0]      quat_x_o,
  output logic signed [e2q_pkg::QuatW-1:0]      quat_y_o,
  output logic signed [e2q_pkg::QuatW-1:0]      quat_z_o
);
  import e2q_pkg::*;

  localparam int N       = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int LaneLat = N + 2;
  localparam int Lat     = LaneLat + 3;

  logic en;
  logic [Lat-1:0] vld_q, vld_d;
  op_e  op_q [LaneLat];
  q30_t sa, ca, sb, cb, sc, cc;

  assign en          = ~vld_q[Lat-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  always_comb begin
    vld_d = {vld_q[Lat-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // carry the angle order alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q[0] <= op_e'(op_i);
      for (int i = 1; i < LaneLat; i++) op_q[i] <= op_q[i-1];
    end
  end

  e2q_cordic_lane #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_a (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_a_i), .sin_o(sa), .cos_o(ca)
  );
  e2q_cordic_lane #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_b (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_b_i), .sin_o(sb), .cos_o(cb)
  );
  e2q_cordic_lane #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_c (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_c_i), .sin_o(sc), .cos_o(cc)
  );

  e2q_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i(clk_i), .en_i(en), .op_i(op_q[LaneLat-1]),
    .sa_i(sa), .ca_i(ca), .sb_i(sb), .cb_i(cb), .sc_i(sc), .cc_i(cc),
    .quat_w_o(quat_w_o), .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o), .quat_z_o(quat_z_o)
  );

endmodule
`default_nettype wire

/* design/e2q_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_ready_o,
  input wire out_valid_o,
  input wire out_ready_i,
  input wire logic signed [17:0] quat_w_o,
  input wire logic signed [17:0] quat_x_o
);

  // take an item whenever the output stage is free to move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready does not follow output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_w_o))
    else $error("stalled result dropped or changed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quat_w_o <= 18'sd65536 && quat_w_o >= -18'sd65536 &&
                     quat_x_o <= 18'sd65536 && quat_x_o >= -18'sd65536))
    else $error("component beyond unit range");

endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .quat_w_o(quat_w_o), .quat_x_o(quat_x_o)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives Euler angle triples in all four angle orders into the quaternion
// converter and checks every output item against a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb;
  import e2q_pkg::*;

  localparam int FracBits    = FracBitsDefault;
  localparam int CordicSteps = CordicStepsDefault;
  localparam int Latency     = CordicSteps + 5;
  localparam longint CycleLimit = 400000;
  localparam logic signed [AngleW-1:0] AngleMax = 20'sd411775;

  typedef struct packed {
    logic signed [QuatW-1:0] w;
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [OpW-1:0] op_i = '0;
  logic signed [AngleW-1:0] angle_a_i = '0, angle_b_i = '0, angle_c_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [QuatW-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_t expected_quats[$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit stall_allowed = 1'b1;

  euler_to_quaternion_unit uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Arithmetic right shift on 64-bit signed values.
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint t[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                      64'sd534100635, 64'sd268086748, 64'sd134174063,
                      64'sd67103403, 64'sd33553749, 64'sd16777131,
                      64'sd8388597, 64'sd4194303};
    return (i < 11) ? t[i] : (64'sd1 <<< (32 - i));
  endfunction

  function automatic void half_sin_cos(input logic signed [AngleW-1:0] ang,
                                       output longint s30, output longint c30);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * (64'sd1 <<< (31 - FracBits));
    x = 64'sd2608131496;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd6746518852) begin
      z -= 64'sd13493037705;
      flip = 1'b1;
    end else if (z < -64'sd6746518852) begin
      z += 64'sd13493037705;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps && i < MaxSteps; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c30 = sra(x + 2, 2);
    s30 = sra(y + 2, 2);
  endfunction

  function automatic longint prod3(longint p, longint q, longint r);
    return sra(p * q + (64'sd1 <<< 29), 30) * r;
  endfunction

  function automatic logic signed [QuatW-1:0] round_sat(longint sum60);
    longint lim, v;
    lim = 64'sd1 <<< FracBits;
    v = sra(sum60 + (64'sd1 <<< (59 - FracBits)), 60 - FracBits);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[QuatW-1:0];
  endfunction

  function automatic quat_t predict_quat(op_e op, logic signed [AngleW-1:0] a,
                                         logic signed [AngleW-1:0] b,
                                         logic signed [AngleW-1:0] c);
    longint sa, ca, sb, cb, sc, cc, w, x, y, z;
    quat_t q;
    half_sin_cos(a, sa, ca);
    half_sin_cos(b, sb, cb);
    half_sin_cos(c, sc, cc);
    case (op)
      OP_RPY: begin
        w = prod3(ca, cb, cc) + prod3(sa, sb, sc);
        x = prod3(cb, cc, sa) - prod3(ca, sb, sc);
        y = prod3(ca, cc, sb) + prod3(cb, sa, sc);
        z = prod3(ca, cb, sc) - prod3(cc, sa, sb);
      end
      OP_XYZ: begin
        w = prod3(ca, cb, cc) - prod3(sa, sb, sc);
        x = prod3(cb, cc, sa) + prod3(ca, sb, sc);
        y = prod3(ca, cc, sb) - prod3(cb, sa, sc);
        z = prod3(ca, cb, sc) + prod3(cc, sa, sb);
      end
      OP_ZXZ: begin
        w = prod3(ca, cb, cc) - prod3(cb, sa, sc);
        x = prod3(ca, cc, sb) + prod3(sa, sb, sc);
        y = prod3(cc, sa, sb) - prod3(ca, sb, sc);
        z = prod3(ca, cb, sc) + prod3(cb, cc, sa);
      end
      default: begin
        w = prod3(ca, cb, cc) + prod3(sa, sb, sc);
        x = prod3(ca, cb, sc) - prod3(cc, sa, sb);
        y = prod3(ca, cc, sb) + prod3(cb, sa, sc);
        z = prod3(cb, cc, sa) - prod3(ca, sb, sc);
      end
    endcase
    q.w = round_sat(w);
    q.x = round_sat(x);
    q.y = round_sat(y);
    q.z = round_sat(z);
    return q;
  endfunction

  task automatic report_mismatch(string what, logic signed [QuatW-1:0] got,
                                 logic signed [QuatW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Send one item; random gap before it when gaps are on. Without a gap,
  // keep valid high straight into the next item.
  task automatic send_angles(op_e op, logic signed [AngleW-1:0] a,
                             logic signed [AngleW-1:0] b,
                             logic signed [AngleW-1:0] c, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    angle_a_i <= a;
    angle_b_i <= b;
    angle_c_i <= c;
    expected_quats.push_back(predict_quat(op, a, b, c));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [AngleW-1:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return AngleW'($urandom);
      1: return AngleW'($urandom_range(0, 2 * 411775) - 411775);
      2: return AngleW'($urandom_range(0, 400) - 200);
      default: return AngleW'($urandom_range(0, 2 * 102944) - 102944);
    endcase
  endfunction

  // Receiver: random stalls, a long hold-off when requested, or always ready when stalls are off.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (stall_allowed) begin
      out_ready_i <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_quats.size() == 0) begin
        $display("unexpected item at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_quats.pop_front();
        if (quat_w_o !== want.w) report_mismatch("w", quat_w_o, want.w);
        if (quat_x_o !== want.x) report_mismatch("x", quat_x_o, want.x);
        if (quat_y_o !== want.y) report_mismatch("y", quat_y_o, want.y);
        if (quat_z_o !== want.z) report_mismatch("z", quat_z_o, want.z);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [AngleW-1:0] edges[8];
    edges = '{20'sd0, AngleMax, -AngleMax, 20'sd102944, -20'sd102944,
              20'sh7FFFF, 20'sh80000, 20'sd205887};
    for (int o = 0; o < 4; o++) begin
      send_angles(op_e'(o), 20'sd0, 20'sd0, 20'sd0, 1'b0);
      send_angles(op_e'(o), AngleMax, -AngleMax, 20'sd102944, 1'b1);
      send_angles(op_e'(o), 20'sh7FFFF, 20'sh80000, 20'sd205887, 1'b0);
    end
    for (int k = 0; k < 8; k++)
      send_angles(op_e'(k % 4), edges[k], edges[(k + 3) % 8], edges[(k + 5) % 8], 1'b1);
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++)
      send_angles(op_e'($urandom_range(0, 3)), rand_angle(), rand_angle(), rand_angle(),
                  $urandom_range(0, 4) != 0);
  endtask

  // Hold the output off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    hold_off = 4 * Latency + 20;
    for (int k = 0; k < 3 * Latency; k++)
      send_angles(op_e'($urandom_range(0, 3)), rand_angle(), rand_angle(), rand_angle(), 1'b0);
  endtask

  task automatic test_burst();
    stall_allowed = 1'b0;
    test_random(200);
    stall_allowed = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_burst();
    test_random(650);
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (2 * Latency) @(posedge clk_i);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
